// File: rtl/core/tapb_pkg.sv
// ----------------------------------------------------------------------------
// tapb_pkg
// Shared types, register indexes and an arithmetic helper for the tinted
// alpha pixel blender.
// ----------------------------------------------------------------------------
package tapb_pkg;

  localparam int ChanW    = 8;
  localparam int TexelW   = 32;
  localparam int DestW    = 24;
  localparam int ProdW    = 2 * ChanW;
  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 8;

  localparam logic [ChanW-1:0] FullScale = 8'hFF;

  localparam logic [CfgIdxW-1:0] RegMode      = 3'd0;
  localparam logic [CfgIdxW-1:0] RegTintRed   = 3'd1;
  localparam logic [CfgIdxW-1:0] RegTintGreen = 3'd2;
  localparam logic [CfgIdxW-1:0] RegTintBlue  = 3'd3;
  localparam logic [CfgIdxW-1:0] RegTintAlpha = 3'd4;

  typedef struct packed {
    logic             mode;
    logic [ChanW-1:0] tint_red;
    logic [ChanW-1:0] tint_green;
    logic [ChanW-1:0] tint_blue;
    logic [ChanW-1:0] tint_alpha;
  } cfg_t;

  typedef struct packed {
    logic en1;
    logic en2;
    logic en3;
    logic en4;
  } ctl_t;

  // floor(x / 255) for x below 65280
  function automatic logic [ChanW-1:0] div255(input logic [ProdW-1:0] x);
    logic [ProdW:0] t;
    t = {1'b0, x} + {{(ChanW+1){1'b0}}, x[ProdW-1:ChanW]} + {{ProdW{1'b0}}, 1'b1};
    return t[ProdW-1:ChanW];
  endfunction

endpackage

// File: rtl/core/tapb_cfg.sv
// ----------------------------------------------------------------------------
// tapb_cfg
// Configuration register file: mode and tint color/opacity.
// ----------------------------------------------------------------------------
module tapb_cfg (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_write,
  input  logic [tapb_pkg::CfgIdxW-1:0]   cfg_index,
  input  logic [tapb_pkg::CfgDataW-1:0]  cfg_data,
  output tapb_pkg::cfg_t                 cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.mode       <= 1'b0;
      cfg.tint_red   <= tapb_pkg::FullScale;
      cfg.tint_green <= tapb_pkg::FullScale;
      cfg.tint_blue  <= tapb_pkg::FullScale;
      cfg.tint_alpha <= tapb_pkg::FullScale;
    end else if (cfg_write) begin
      unique case (cfg_index)
        tapb_pkg::RegMode:      cfg.mode       <= cfg_data[0];
        tapb_pkg::RegTintRed:   cfg.tint_red   <= cfg_data;
        tapb_pkg::RegTintGreen: cfg.tint_green <= cfg_data;
        tapb_pkg::RegTintBlue:  cfg.tint_blue  <= cfg_data;
        tapb_pkg::RegTintAlpha: cfg.tint_alpha <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

// File: rtl/core/tapb_datapath.sv
// ----------------------------------------------------------------------------
// tapb_datapath
// Four-stage blend datapath: alpha product, effective alpha, channel
// products, normalize and output.
// ----------------------------------------------------------------------------
module tapb_datapath (
  input  logic                          clk,
  input  tapb_pkg::ctl_t                ctl,
  input  tapb_pkg::cfg_t                cfg,
  input  logic [tapb_pkg::TexelW-1:0]   texel,
  input  logic [tapb_pkg::DestW-1:0]    dest_pixel,
  output logic                          write_enable,
  output logic [tapb_pkg::TexelW-1:0]   result_pixel
);

  localparam int CW = tapb_pkg::ChanW;
  localparam int PW = tapb_pkg::ProdW;

  // stage 1
  logic [PW-1:0]                 prod1;
  logic                          copy1;
  logic                          zero1;
  logic [tapb_pkg::TexelW-1:0]   texel1;
  logic [3*CW-1:0]               src1;
  logic [3*CW-1:0]               dst1;
  // stage 2
  logic [CW-1:0]                 ea2;
  logic                          skip2;
  logic                          copy2;
  logic [tapb_pkg::TexelW-1:0]   texel2;
  logic [3*CW-1:0]               src2;
  logic [3*CW-1:0]               dst2;
  // stage 3
  logic [PW-1:0]                 sum_r3;
  logic [PW-1:0]                 sum_g3;
  logic [PW-1:0]                 sum_b3;
  logic                          skip3;
  logic                          copy3;
  logic [tapb_pkg::TexelW-1:0]   texel3;

  logic [CW-1:0] ta, tr, tg, tb;
  logic          gray;
  logic [CW-1:0] ea_next;
  logic [CW-1:0] inv_ea;

  assign ta   = texel[31:24];
  assign tr   = texel[23:16];
  assign tg   = texel[15:8];
  assign tb   = texel[7:0];
  assign gray = (tr == tg) && (tg == tb) && (tr != '0);

  always_ff @(posedge clk) begin
    if (ctl.en1) begin
      prod1  <= ta * cfg.tint_alpha;
      copy1  <= cfg.mode;
      zero1  <= (ta == '0);
      texel1 <= texel;
      src1   <= gray ? {cfg.tint_red, cfg.tint_green, cfg.tint_blue} : texel[23:0];
      dst1   <= dest_pixel;
    end
  end

  assign ea_next = tapb_pkg::div255(prod1);

  always_ff @(posedge clk) begin
    if (ctl.en2) begin
      ea2    <= ea_next;
      skip2  <= zero1 || (!copy1 && (ea_next == '0));
      copy2  <= copy1;
      texel2 <= texel1;
      src2   <= src1;
      dst2   <= dst1;
    end
  end

  assign inv_ea = tapb_pkg::FullScale - ea2;

  always_ff @(posedge clk) begin
    if (ctl.en3) begin
      sum_r3 <= src2[23:16] * ea2 + dst2[23:16] * inv_ea;
      sum_g3 <= src2[15:8]  * ea2 + dst2[15:8]  * inv_ea;
      sum_b3 <= src2[7:0]   * ea2 + dst2[7:0]   * inv_ea;
      skip3  <= skip2;
      copy3  <= copy2;
      texel3 <= texel2;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.en4) begin
      write_enable <= !skip3;
      if (skip3) begin
        result_pixel <= '0;
      end else if (copy3) begin
        result_pixel <= texel3;
      end else begin
        result_pixel <= {tapb_pkg::FullScale, tapb_pkg::div255(sum_r3),
                         tapb_pkg::div255(sum_g3), tapb_pkg::div255(sum_b3)};
      end
    end
  end

endmodule

// File: rtl/core/tinted_alpha_pixel_blend.sv
// ----------------------------------------------------------------------------
// tinted_alpha_pixel_blend
// Tinted source-over compositing of one ARGB texel onto one RGB pixel.
// Throughput: one transfer per cycle while the output is not stalled, set by
// the four-stage pipeline (valid bits v1, v2, v3, out_valid); each stage
// advances on its own, so bubbles close up under output stall.
// Reset: synchronous; clears all stage valid bits, mode to blend, tints to 0xFF.
// ----------------------------------------------------------------------------
module tinted_alpha_pixel_blend (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_write,
  input  logic [tapb_pkg::CfgIdxW-1:0]  cfg_index,
  input  logic [tapb_pkg::CfgDataW-1:0] cfg_data,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [tapb_pkg::TexelW-1:0]   texel,
  input  logic [tapb_pkg::DestW-1:0]    dest_pixel,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          write_enable,
  output logic [tapb_pkg::TexelW-1:0]   result_pixel
);

  tapb_pkg::cfg_t cfg;
  tapb_pkg::ctl_t ctl;
  logic v1, v2, v3;

  assign ctl.en4  = !out_valid || !out_stall;
  assign ctl.en3  = !v3 || ctl.en4;
  assign ctl.en2  = !v2 || ctl.en3;
  assign ctl.en1  = !v1 || ctl.en2;
  assign in_stall = !ctl.en1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      v3        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (ctl.en1) v1 <= in_valid;
      if (ctl.en2) v2 <= v1;
      if (ctl.en3) v3 <= v2;
      if (ctl.en4) out_valid <= v3;
    end
  end

  tapb_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  tapb_datapath u_datapath (
    .clk          (clk),
    .ctl          (ctl),
    .cfg          (cfg),
    .texel        (texel),
    .dest_pixel   (dest_pixel),
    .write_enable (write_enable),
    .result_pixel (result_pixel)
  );

endmodule

// File: tb/tinted_alpha_pixel_blend_tb.sv
// ----------------------------------------------------------------------------
// tinted_alpha_pixel_blend_tb
// Self-checking bench for the tinted alpha pixel blender. A directed table
// covers reset values, transparent and zero-alpha texels, gray and black
// texels, copy mode and wide register writes. It is followed by random
// phases under changing register settings, with random gaps on the input
// side and random stall on the output side. Results are compared with the
// table's expected value or, elsewhere, with a behavioral blend predictor.
// ----------------------------------------------------------------------------
module tinted_alpha_pixel_blend_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned Full       = 255;
  localparam int          QuietLimit = 1000;
  localparam int          NumPhases  = 6;
  localparam int          PhaseItems = 90;

  typedef struct packed {
    logic        we;
    logic [31:0] pix;
  } pix_result_t;

  typedef struct {
    logic [39:0] cfg;   // {mode, red, green, blue, alpha} as written
    logic [31:0] tx;
    logic [23:0] dst;
    bit          chk;
    pix_result_t want;
  } dir_row_t;

  logic                          clk;
  logic                          rst;
  logic                          cfg_write;
  logic [tapb_pkg::CfgIdxW-1:0]  cfg_index;
  logic [tapb_pkg::CfgDataW-1:0] cfg_data;
  logic                          in_valid;
  logic                          in_stall;
  logic [tapb_pkg::TexelW-1:0]   texel;
  logic [tapb_pkg::DestW-1:0]    dest_pixel;
  logic                          out_valid;
  logic                          out_stall;
  logic                          write_enable;
  logic [tapb_pkg::TexelW-1:0]   result_pixel;

  logic       m_mode;
  logic [7:0] m_red, m_green, m_blue, m_alpha;

  pix_result_t pending_writes[$];
  dir_row_t    dir_rows[$];

  int sent_count;
  int write_count;
  int skip_count;
  int mismatch_count;
  int settings_loaded;

  tinted_alpha_pixel_blend u_dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .texel        (texel),
    .dest_pixel   (dest_pixel),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .write_enable (write_enable),
    .result_pixel (result_pixel)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic int unsigned mix_chan(input int unsigned s, input int unsigned d,
                                           input int unsigned a);
    return (s * a + d * (Full - a)) / Full;
  endfunction

  function automatic pix_result_t predict_blend(input logic [31:0] tx, input logic [23:0] dst);
    pix_result_t r;
    int unsigned ea;
    logic [7:0]  sr, sg, sb;
    r = '0;
    if (tx[31:24] == 8'd0) return r;
    if (m_mode) begin
      r.we  = 1'b1;
      r.pix = tx;
      return r;
    end
    ea = (int'(tx[31:24]) * int'(m_alpha)) / Full;
    if (ea == 0) return r;
    if (tx[23:16] == tx[15:8] && tx[15:8] == tx[7:0] && tx[23:16] != 8'd0) begin
      sr = m_red;
      sg = m_green;
      sb = m_blue;
    end else begin
      sr = tx[23:16];
      sg = tx[15:8];
      sb = tx[7:0];
    end
    r.we  = 1'b1;
    r.pix = {8'hFF,
             8'(mix_chan(sr, dst[23:16], ea)),
             8'(mix_chan(sg, dst[15:8], ea)),
             8'(mix_chan(sb, dst[7:0], ea))};
    return r;
  endfunction

  function automatic void model_write(input logic [tapb_pkg::CfgIdxW-1:0] idx,
                                      input logic [tapb_pkg::CfgDataW-1:0] data);
    case (idx)
      tapb_pkg::RegMode:      m_mode  = data[0];
      tapb_pkg::RegTintRed:   m_red   = data;
      tapb_pkg::RegTintGreen: m_green = data;
      tapb_pkg::RegTintBlue:  m_blue  = data;
      tapb_pkg::RegTintAlpha: m_alpha = data;
      default: ;
    endcase
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic logic [7:0] pick_chan();
    int r;
    r = $urandom_range(0, 99);
    if (r < 20) return 8'h00;
    if (r < 40) return 8'hFF;
    return 8'($urandom);
  endfunction

  function automatic logic [31:0] rand_texel();
    int         r;
    logic [7:0] a, lvl;
    r = $urandom_range(0, 99);
    if (r < 10)      a = 8'h00;
    else if (r < 25) a = 8'hFF;
    else if (r < 35) a = 8'($urandom_range(1, 4));
    else             a = 8'($urandom);
    r = $urandom_range(0, 99);
    if (r < 5) return {a, 24'h000000};
    if (r < 35) begin
      lvl = 8'($urandom);
      return {a, lvl, lvl, lvl};
    end
    return {a, 24'($urandom)};
  endfunction

  function automatic logic [23:0] rand_dest();
    int r;
    r = $urandom_range(0, 99);
    if (r < 15) return 24'h000000;
    if (r < 30) return 24'hFFFFFF;
    return 24'($urandom);
  endfunction

  task automatic note_mismatch(input string msg);
    mismatch_count++;
    if (mismatch_count <= 10) $display("MISMATCH @%0t: %s", $realtime, msg);
  endtask

  task automatic add_row(input logic [39:0] cfg, input logic [31:0] tx, input logic [23:0] dst,
                         input bit chk, input logic we, input logic [31:0] pix);
    dir_row_t row;
    row.cfg      = cfg;
    row.tx       = tx;
    row.dst      = dst;
    row.chk      = chk;
    row.want.we  = we;
    row.want.pix = pix;
    dir_rows.push_back(row);
  endtask

  task automatic idle_gap(input int n);
    if (n > 0) begin
      in_valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  // Called right after a rising edge; returns at the edge of the transfer.
  task automatic push_pixel(input logic [31:0] tx, input logic [23:0] dst, input bit chk,
                            input pix_result_t want);
    in_valid   <= 1'b1;
    texel      <= tx;
    dest_pixel <= dst;
    do @(negedge clk); while (in_stall !== 1'b0);
    pending_writes.push_back(chk ? want : predict_blend(tx, dst));
    sent_count++;
    @(posedge clk);
  endtask

  // Drain the pipeline, then write all indexes, including the unused ones.
  task automatic load_settings(input logic [39:0] cfg);
    logic [tapb_pkg::CfgDataW-1:0] vals [8];
    in_valid <= 1'b0;
    while (pending_writes.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
    vals[0] = cfg[39:32];
    vals[1] = cfg[31:24];
    vals[2] = cfg[23:16];
    vals[3] = cfg[15:8];
    vals[4] = cfg[7:0];
    for (int i = 5; i < 8; i++) vals[i] = tapb_pkg::CfgDataW'($urandom);
    cfg_write <= 1'b1;
    for (int i = 0; i < 8; i++) begin
      cfg_index <= tapb_pkg::CfgIdxW'(i);
      cfg_data  <= vals[i];
      @(posedge clk);
      model_write(tapb_pkg::CfgIdxW'(i), vals[i]);
    end
    cfg_write <= 1'b0;
    settings_loaded++;
  endtask

  initial begin : out_stall_gen
    int run;
    bit st;
    out_stall = 1'b0;
    run = 0;
    st  = 1'b0;
    forever begin
      @(posedge clk);
      if (run == 0) begin
        if ($urandom_range(0, 2) == 0) begin
          st  = 1'b1;
          run = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
        end else begin
          st  = 1'b0;
          run = $urandom_range(1, 40);
        end
      end
      out_stall <= st;
      run--;
    end
  end

  initial begin : result_check
    pix_result_t want;
    forever begin
      @(negedge clk);
      if (!rst && out_valid === 1'b1 && out_stall === 1'b0) begin
        if (pending_writes.size() == 0) begin
          note_mismatch($sformatf("unexpected result we=%b pix=%h", write_enable, result_pixel));
        end else begin
          want = pending_writes.pop_front();
          if (want.we) write_count++;
          else skip_count++;
          if (write_enable !== want.we || result_pixel !== want.pix)
            note_mismatch($sformatf("exp we=%b pix=%h, got we=%b pix=%h",
                                    want.we, want.pix, write_enable, result_pixel));
        end
      end
    end
  end

  initial begin : watchdog
    int  quiet;
    bit  moved;
    quiet = 0;
    while (quiet < QuietLimit) begin
      @(negedge clk);
      moved = (in_valid === 1'b1 && in_stall === 1'b0) ||
              (out_valid === 1'b1 && out_stall === 1'b0);
      quiet = moved ? 0 : quiet + 1;
    end
    $display("Timeout: no transfer for %0d cycles", QuietLimit);
    $display("Regression FAIL");
    $finish;
  end

  initial begin : stimulus
    logic [39:0] applied;
    logic [39:0] cfg;
    logic        mode_bit;
    logic [7:0]  alpha;
    rst        = 1'b1;
    cfg_write  = 1'b0;
    cfg_index  = '0;
    cfg_data   = '0;
    in_valid   = 1'b0;
    texel      = '0;
    dest_pixel = '0;
    m_mode     = 1'b0;
    m_red      = 8'hFF;
    m_green    = 8'hFF;
    m_blue     = 8'hFF;
    m_alpha    = 8'hFF;
    applied    = 40'h00_FF_FF_FF_FF;
    sent_count = 0;
    write_count = 0;
    skip_count = 0;
    mismatch_count = 0;
    settings_loaded = 0;

    // reset settings: transparent, black, gray, full alpha
    add_row(40'h00_FF_FF_FF_FF, 32'h00FFFFFF, 24'h123456, 1, 1'b0, 32'h0);
    add_row(40'h00_FF_FF_FF_FF, 32'h00000000, 24'hFFFFFF, 1, 1'b0, 32'h0);
    add_row(40'h00_FF_FF_FF_FF, 32'hFF000000, 24'hFFFFFF, 1, 1'b1, 32'hFF000000);
    add_row(40'h00_FF_FF_FF_FF, 32'hFF808080, 24'h000000, 1, 1'b1, 32'hFFFFFFFF);
    add_row(40'h00_FF_FF_FF_FF, 32'hFF123456, 24'hABCDEF, 1, 1'b1, 32'hFF123456);
    add_row(40'h00_FF_FF_FF_FF, 32'hFFFFFFFF, 24'h000000, 1, 1'b1, 32'hFFFFFFFF);
    add_row(40'h00_FF_FF_FF_FF, 32'h01FFFFFF, 24'h000000, 0, 1'b0, 32'h0);
    add_row(40'h00_FF_FF_FF_FF, 32'h80102030, 24'hA0B0C0, 0, 1'b0, 32'h0);
    add_row(40'h00_FF_FF_FF_FF, 32'h7F010101, 24'hFFFFFF, 0, 1'b0, 32'h0);
    // effective alpha truncates to zero or to one
    add_row(40'h00_FF_FF_FF_00, 32'hFF123456, 24'h654321, 1, 1'b0, 32'h0);
    add_row(40'h00_FF_FF_FF_00, 32'hFFFFFFFF, 24'h000000, 1, 1'b0, 32'h0);
    add_row(40'h00_FF_FF_FF_01, 32'hFE123456, 24'h000000, 1, 1'b0, 32'h0);
    add_row(40'h00_FF_FF_FF_01, 32'hFF123456, 24'h000000, 0, 1'b0, 32'h0);
    // mode written with upper bits set, low bit clear: still blend; then black tint at half alpha
    add_row(40'hFE_10_20_30_FF, 32'hFF555555, 24'h000000, 1, 1'b1, 32'hFF102030);
    add_row(40'hFE_10_20_30_FF, 32'hFF555556, 24'h000000, 1, 1'b1, 32'hFF555556);
    add_row(40'hFE_10_20_30_FF, 32'h80AAAAAA, 24'hFFFFFF, 0, 1'b0, 32'h0);
    add_row(40'h00_00_00_00_80, 32'hFFC0C0C0, 24'hFFFFFF, 0, 1'b0, 32'h0);
    add_row(40'h00_00_00_00_80, 32'h40000000, 24'h00FF00, 0, 1'b0, 32'h0);
    // copy mode
    add_row(40'h01_FF_FF_FF_FF, 32'h01ABCDEF, 24'h000000, 1, 1'b1, 32'h01ABCDEF);
    add_row(40'h01_FF_FF_FF_FF, 32'h00ABCDEF, 24'h000000, 1, 1'b0, 32'h0);
    add_row(40'h01_FF_FF_FF_FF, 32'hFF808080, 24'h123456, 1, 1'b1, 32'hFF808080);
    add_row(40'hFF_00_00_00_00, 32'h80112233, 24'h000000, 1, 1'b1, 32'h80112233);
    add_row(40'hFF_00_00_00_00, 32'h00FFFFFF, 24'hFFFFFF, 1, 1'b0, 32'h0);
    add_row(40'hFF_00_00_00_00, 32'hFFFFFFFF, 24'hFFFFFF, 1, 1'b1, 32'hFFFFFFFF);

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    foreach (dir_rows[i]) begin
      if (dir_rows[i].cfg != applied) begin
        load_settings(dir_rows[i].cfg);
        applied = dir_rows[i].cfg;
      end else begin
        idle_gap(pick_gap());
      end
      push_pixel(dir_rows[i].tx, dir_rows[i].dst, dir_rows[i].chk, dir_rows[i].want);
    end

    for (int p = 0; p < NumPhases; p++) begin
      mode_bit = (p == 2 || p == 5);
      case (p)
        1:       alpha = 8'hFF;
        3:       alpha = 8'($urandom_range(1, 8));
        default: alpha = pick_chan();
      endcase
      cfg = {7'($urandom), mode_bit, pick_chan(), pick_chan(), pick_chan(), alpha};
      load_settings(cfg);
      for (int k = 0; k < PhaseItems; k++) begin
        if (p != 1) idle_gap(pick_gap());
        push_pixel(rand_texel(), rand_dest(), 1'b0, '0);
      end
    end
    in_valid <= 1'b0;

    while (pending_writes.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("Sent %0d pixel transfers under %0d register settings (blend, copy, tint extremes)",
             sent_count, settings_loaded);
    $display("Results: %0d writes, %0d skips, %0d mismatches",
             write_count, skip_count, mismatch_count);
    if (mismatch_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// File: filelist.f
rtl/core/tapb_pkg.sv
rtl/core/tapb_cfg.sv
rtl/core/tapb_datapath.sv
rtl/core/tinted_alpha_pixel_blend.sv
tb/tinted_alpha_pixel_blend_tb.sv
